FILE: design/iws_pkg.sv
// ---------------------------------------------------------------------------
// Interval window statistics package
// Shared sizes, opcodes, sequencer states and ring arithmetic.
// ---------------------------------------------------------------------------
package iws_pkg;

    localparam int unsigned DEPTH      = 64;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
    localparam int unsigned TS_W       = 32;
    localparam int unsigned ENTRY_W    = 7;
    localparam int unsigned SUM_W      = TS_W + CNT_W;
    localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam logic [TS_W-1:0] SPAN_RESET = 32'd500000;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_END    = 2'd1,
        OP_REPORT = 2'd2,
        OP_SPARE  = 2'd3
    } opcode_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_APPLY = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_STATS = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Ring position of the k-th held entry counted from the oldest one.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(k);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(s);
    endfunction

endpackage

FILE: design/interval_window_statistics_unit.sv
// ---------------------------------------------------------------------------
// Interval window statistics unit
// Holds a ring of timed intervals, evicts old ones after each end request and
// reports longest, shortest and mean duration with the entry count.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_opcode, s_timestamp
//  m_        out        m_valid/m_ready    m_empty_res, m_peak_ticks, m_low_ticks,
//                                          m_mean_ticks, m_entry_count
//  cfg_      in         cfg_we (no wait)   cfg_wdata (time span)
//
// Each request makes one pass over the end-time memory for eviction (end requests
// only), one pass over both memories for the statistics, and a restoring divider
// that retires one quotient bit a cycle.
// s_ready is high only in the idle state; a finished result waits in the output
// register, and the next request may be taken while it does.
// aresetn is synchronous and active low; it empties the window.
// ---------------------------------------------------------------------------
module interval_window_statistics_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_opcode,
    input  logic [iws_pkg::TS_W-1:0]     s_timestamp,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_empty_res,
    output logic [iws_pkg::TS_W-1:0]     m_peak_ticks,
    output logic [iws_pkg::TS_W-1:0]     m_low_ticks,
    output logic [iws_pkg::TS_W-1:0]     m_mean_ticks,
    output logic [iws_pkg::ENTRY_W-1:0]  m_entry_count,
    input  logic                         cfg_we,
    input  logic [iws_pkg::TS_W-1:0]     cfg_wdata
);

    localparam int unsigned IDX_W = iws_pkg::IDX_W;
    localparam int unsigned CNT_W = iws_pkg::CNT_W;
    localparam int unsigned TS_W  = iws_pkg::TS_W;
    localparam int unsigned SUM_W = iws_pkg::SUM_W;
    localparam int unsigned DCW   = iws_pkg::DIV_CNT_W;

    logic [TS_W-1:0] begin_mem [iws_pkg::DEPTH];
    logic [TS_W-1:0] end_mem   [iws_pkg::DEPTH];

    iws_pkg::state_t  state_reg, state_next;
    logic [TS_W-1:0]  span_reg;
    logic [IDX_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rd_k_reg, rd_k_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             first_reg, first_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic             m_valid_reg, m_valid_next;

    iws_pkg::opcode_t op_reg;
    logic [TS_W-1:0]  ts_reg;
    logic [TS_W-1:0]  begin_q, end_q;
    logic [TS_W-1:0]  dur_reg, dur_next;
    logic [TS_W-1:0]  peak_reg, peak_next;
    logic [TS_W-1:0]  low_reg, low_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic             empty_reg, empty_next;

    logic             we_begin, we_end;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [CNT_W:0]   trial;
    logic             load_out;

    assign s_ready = (state_reg == iws_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign trial   = {rem_reg, acc_reg[SUM_W-1]};
    assign load_out = (state_reg == iws_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        oldest_next  = oldest_reg;
        held_next    = held_reg;
        cnt_next     = cnt_reg;
        rd_k_next    = rd_k_reg;
        v1_next      = 1'b0;
        v2_next      = 1'b0;
        first_next   = first_reg;
        div_cnt_next = div_cnt_reg;
        dur_next     = end_q - begin_q;
        peak_next    = peak_reg;
        low_next     = low_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        empty_next   = empty_reg;
        we_begin     = 1'b0;
        we_end       = 1'b0;
        wr_addr      = iws_pkg::ring_add(oldest_reg, held_reg);
        rd_addr      = iws_pkg::ring_add(oldest_reg, cnt_reg);
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            iws_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = iws_pkg::ST_APPLY;
                end
            end
            iws_pkg::ST_APPLY: begin
                state_next = iws_pkg::ST_STATS;
                cnt_next   = '0;
                first_next = 1'b1;
                acc_next   = '0;
                case (op_reg)
                    iws_pkg::OP_START: begin
                        we_begin = 1'b1;
                        we_end   = 1'b1;
                        // On a full ring the new entry takes the oldest slot.
                        if (held_reg == CNT_W'(iws_pkg::DEPTH)) begin
                            wr_addr     = oldest_reg;
                            oldest_next = iws_pkg::ring_add(oldest_reg, CNT_W'(1));
                        end else begin
                            held_next = held_reg + CNT_W'(1);
                        end
                    end
                    iws_pkg::OP_END: begin
                        if (held_reg != '0) begin
                            we_end     = 1'b1;
                            wr_addr    = iws_pkg::ring_add(oldest_reg, held_reg - CNT_W'(1));
                            cnt_next   = held_reg;
                            state_next = iws_pkg::ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            iws_pkg::ST_SCAN: begin
                // Reads are issued newest first; read data arrives in the cycle after.
                if (cnt_reg != '0) begin
                    rd_addr   = iws_pkg::ring_add(oldest_reg, cnt_reg - CNT_W'(1));
                    rd_k_next = cnt_reg - CNT_W'(1);
                    cnt_next  = cnt_reg - CNT_W'(1);
                    v1_next   = 1'b1;
                end
                if (v1_reg && ((ts_reg - end_q) > span_reg)) begin
                    oldest_next = iws_pkg::ring_add(oldest_reg, rd_k_reg);
                    held_next   = held_reg - rd_k_reg;
                    state_next  = iws_pkg::ST_STATS;
                    cnt_next    = '0;
                    v1_next     = 1'b0;
                end else if (cnt_reg == '0 && !v1_reg) begin
                    state_next = iws_pkg::ST_STATS;
                    cnt_next   = '0;
                end
            end
            iws_pkg::ST_STATS: begin
                if (cnt_reg != held_reg) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    v1_next  = 1'b1;
                end
                v2_next = v1_reg;
                if (v2_reg) begin
                    first_next = 1'b0;
                    acc_next   = acc_reg + SUM_W'(dur_reg);
                    if (first_reg || dur_reg > peak_reg) begin
                        peak_next = dur_reg;
                    end
                    if (first_reg || dur_reg < low_reg) begin
                        low_next = dur_reg;
                    end
                end
                if (cnt_reg == held_reg && !v1_reg && !v2_reg) begin
                    empty_next = (held_reg == '0);
                    rem_next   = '0;
                    div_cnt_next = DCW'(SUM_W);
                    state_next = (held_reg == '0) ? iws_pkg::ST_DONE : iws_pkg::ST_DIV;
                end
            end
            iws_pkg::ST_DIV: begin
                // Restoring division: the accumulator shifts out the dividend
                // and shifts in the quotient.
                if (trial >= (CNT_W+1)'(held_reg)) begin
                    rem_next = CNT_W'(trial - (CNT_W+1)'(held_reg));
                    acc_next = {acc_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_next = CNT_W'(trial);
                    acc_next = {acc_reg[SUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1)) begin
                    state_next = iws_pkg::ST_DONE;
                end
            end
            iws_pkg::ST_DONE: begin
                if (load_out) begin
                    m_valid_next = 1'b1;
                    state_next   = iws_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iws_pkg::ST_IDLE;
            span_reg    <= iws_pkg::SPAN_RESET;
            oldest_reg  <= '0;
            held_reg    <= '0;
            cnt_reg     <= '0;
            rd_k_reg    <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            first_reg   <= 1'b1;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            oldest_reg  <= oldest_next;
            held_reg    <= held_next;
            cnt_reg     <= cnt_next;
            rd_k_reg    <= rd_k_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            first_reg   <= first_next;
            div_cnt_reg <= div_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                span_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= iws_pkg::opcode_t'(s_opcode);
            ts_reg <= s_timestamp;
        end
        dur_reg   <= dur_next;
        peak_reg  <= peak_next;
        low_reg   <= low_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        empty_reg <= empty_next;
        if (load_out) begin
            m_empty_res   <= empty_reg;
            m_peak_ticks  <= empty_reg ? '0 : peak_reg;
            m_low_ticks   <= empty_reg ? '0 : low_reg;
            m_mean_ticks  <= empty_reg ? '0 : acc_reg[TS_W-1:0];
            m_entry_count <= iws_pkg::ENTRY_W'(held_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (we_begin) begin
            begin_mem[wr_addr] <= ts_reg;
        end
        if (we_end) begin
            end_mem[wr_addr] <= ts_reg;
        end
        begin_q <= begin_mem[rd_addr];
        end_q   <= end_mem[rd_addr];
    end

endmodule
